@@ rtl/core/i2c_ras_pkg.sv @@
// Shared types and constants for the I2C register access sequencer.
`default_nettype none

package i2c_ras_pkg;

	localparam int unsigned ADDR_W  = 7;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [ADDR_W-1:0] DEV0_ADDR_RST = 7'h41;
	localparam logic [ADDR_W-1:0] DEV1_ADDR_RST = 7'h40;

	localparam logic [CFG_IDX_W-1:0] CFG_DEV0_ADDR = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV1_ADDR = 1'b1;

	localparam logic [1:0] DEV_SEL_ZERO = 2'd0;

	localparam logic [1:0] ACK_KEEP    = 2'd0;
	localparam logic [1:0] ACK_ENABLE  = 2'd1;
	localparam logic [1:0] ACK_DISABLE = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_STATUS = 2'd2,
		OP_ERROR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_W_PTR  = 4'd1,
		ST_W_HIGH = 4'd2,
		ST_W_LOW  = 4'd3,
		ST_W_END  = 4'd4,
		ST_R_PTR  = 4'd5,
		ST_R_ADDR = 4'd6,
		ST_R_HIGH = 4'd7,
		ST_R_LOW  = 4'd8
	} seq_state_t;

	typedef struct packed {
		op_t               op;
		logic [1:0]        device_sel;
		logic [BYTE_W-1:0] reg_index;
		logic [WORD_W-1:0] write_data;
		logic [3:0]        status_bits;
		logic [3:0]        error_bits;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic              cmd_rejected;
		logic              drive_valid;
		logic [BYTE_W-1:0] drive_byte;
		logic              start_req;
		logic              stop_req;
		logic [1:0]        ack_ctrl;
		logic              read_done;
		logic [WORD_W-1:0] read_value;
		logic              busy_res;
		logic              bus_error;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/core/i2c_ras_cfg.sv @@
// Device address registers written through the configuration port.
`default_nettype none

module i2c_ras_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [i2c_ras_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [i2c_ras_pkg::ADDR_W-1:0]    cfg_data,
	output logic      [i2c_ras_pkg::ADDR_W-1:0]    dev0_addr,
	output logic      [i2c_ras_pkg::ADDR_W-1:0]    dev1_addr
);
	import i2c_ras_pkg::*;

	logic [ADDR_W-1:0] dev0_addr_q;
	logic [ADDR_W-1:0] dev1_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev0_addr_q <= DEV0_ADDR_RST;
			dev1_addr_q <= DEV1_ADDR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEV0_ADDR: dev0_addr_q <= cfg_data;
				CFG_DEV1_ADDR: dev1_addr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dev0_addr = dev0_addr_q;
	assign dev1_addr = dev1_addr_q;

endmodule

`default_nettype wire

@@ rtl/core/i2c_ras_seq.sv @@
// Transaction state machine: one step per item, result computed combinationally.
`default_nettype none

module i2c_ras_seq (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           step_en,
	input  wire i2c_ras_pkg::item_t             item,
	input  wire logic [i2c_ras_pkg::ADDR_W-1:0] dev0_addr,
	input  wire logic [i2c_ras_pkg::ADDR_W-1:0] dev1_addr,
	output i2c_ras_pkg::result_t                result
);
	import i2c_ras_pkg::*;

	seq_state_t        state_q, state_d;
	logic              pend_q, pend_d;
	logic              err_q, err_d;
	logic [BYTE_W-1:0] addr_byte_q, addr_byte_d;
	logic [ADDR_W-1:0] target_q, target_d;
	logic [BYTE_W-1:0] ptr_q, ptr_d;
	logic [BYTE_W-1:0] tx_high_q, tx_high_d;
	logic [BYTE_W-1:0] tx_low_q, tx_low_d;
	logic [BYTE_W-1:0] rx_high_q, rx_high_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			err_q   <= 1'b0;
		end else if (step_en) begin
			state_q <= state_d;
			pend_q  <= pend_d;
			err_q   <= err_d;
		end
	end

	// payload only, always written before it is read
	always_ff @(posedge clk) begin
		if (step_en) begin
			addr_byte_q <= addr_byte_d;
			target_q    <= target_d;
			ptr_q       <= ptr_d;
			tx_high_q   <= tx_high_d;
			tx_low_q    <= tx_low_d;
			rx_high_q   <= rx_high_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		pend_d      = pend_q;
		err_d       = err_q;
		addr_byte_d = addr_byte_q;
		target_d    = target_q;
		ptr_d       = ptr_q;
		tx_high_d   = tx_high_q;
		tx_low_d    = tx_low_q;
		rx_high_d   = rx_high_q;
		result      = '0;

		unique case (item.op)
			OP_WRITE, OP_READ: begin
				if (state_q != ST_IDLE || item.device_sel[1]) begin
					result.cmd_rejected = 1'b1;
				end else begin
					target_d    = (item.device_sel == DEV_SEL_ZERO) ? dev0_addr : dev1_addr;
					addr_byte_d = {target_d, 1'b0};
					ptr_d       = item.reg_index;
					err_d       = 1'b0;
					result.start_req = 1'b1;
					if (item.op == OP_WRITE) begin
						tx_high_d = item.write_data[WORD_W-1:BYTE_W];
						tx_low_d  = item.write_data[BYTE_W-1:0];
						pend_d    = 1'b0;
						state_d   = ST_W_PTR;
					end else begin
						pend_d  = 1'b1;
						state_d = ST_R_PTR;
					end
				end
			end
			OP_STATUS: begin
				if (state_q != ST_IDLE) begin
					// lowest set status bit wins
					priority if (item.status_bits[0]) begin
						result.drive_valid = 1'b1;
						result.drive_byte  = addr_byte_q;
					end else if (item.status_bits[1]) begin
						if (state_q == ST_R_ADDR) begin
							state_d = ST_R_HIGH;
							result.ack_ctrl = ACK_ENABLE;
						end
					end else if (item.status_bits[2]) begin
						unique case (state_q)
							ST_W_PTR: begin
								result.drive_valid = 1'b1;
								result.drive_byte  = ptr_q;
								state_d = ST_W_HIGH;
							end
							ST_W_HIGH: begin
								result.drive_valid = 1'b1;
								result.drive_byte  = tx_high_q;
								state_d = ST_W_LOW;
							end
							ST_W_LOW: begin
								result.drive_valid = 1'b1;
								result.drive_byte  = tx_low_q;
								state_d = ST_W_END;
							end
							ST_R_PTR: begin
								result.drive_valid = 1'b1;
								result.drive_byte  = ptr_q;
								state_d = ST_W_END;
							end
							ST_W_END: begin
								result.stop_req = 1'b1;
								if (pend_q) begin
									// stop and restart with the read address
									pend_d      = 1'b0;
									addr_byte_d = {target_q, 1'b1};
									result.start_req = 1'b1;
									state_d = ST_R_ADDR;
								end else begin
									state_d = ST_IDLE;
								end
							end
							default: ;
						endcase
					end else if (item.status_bits[3]) begin
						if (state_q == ST_R_HIGH) begin
							rx_high_d = item.rx_byte;
							result.ack_ctrl = ACK_DISABLE;
							result.stop_req = 1'b1;
							state_d = ST_R_LOW;
						end else if (state_q == ST_R_LOW) begin
							result.read_done  = 1'b1;
							result.read_value = {rx_high_q, item.rx_byte};
							state_d = ST_IDLE;
						end
					end else begin
						// no status flag set: ignored
					end
				end
			end
			OP_ERROR: begin
				result.stop_req = item.error_bits[0];
				err_d   = 1'b1;
				pend_d  = 1'b0;
				state_d = ST_IDLE;
			end
			default: ;
		endcase

		result.busy_res  = (state_d != ST_IDLE);
		result.bus_error = err_d;
	end

endmodule

`default_nettype wire

@@ rtl/core/i2c_register_access_sequencer.sv @@
// Top level: input stage, sequencer step and result register with stream handshakes.
// An accepted item is registered; its result then enters the result register.
// Throughput: one item per cycle; the two-stage pipeline advances whenever the
// result register is empty or being taken, and s_tready follows that directly.
// Reset (arst_n low, asynchronous): pipeline emptied, sequencer idle, error flag
// cleared, device addresses back to 0x41 and 0x40. No clearing pass.
`default_nettype none

module i2c_register_access_sequencer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [6:0]  cfg_data,
	// item input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// s_tdata, low bit up: device_sel[1:0], reg_index[9:2], write_data[25:10],
	// status_bits[29:26], error_bits[33:30], rx_byte[41:34], zero fill [47:42]
	input  wire logic [47:0] s_tdata,
	// s_tuser: op[1:0]
	input  wire logic [1:0]  s_tuser,
	// result output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// m_tdata, low bit up: cmd_rejected[0], drive_valid[1], drive_byte[9:2],
	// start_req[10], stop_req[11], ack_ctrl[13:12], read_done[14],
	// read_value[30:15], busy_res[31], bus_error[32], zero fill [39:33]
	output logic [39:0]      m_tdata
);
	import i2c_ras_pkg::*;

	logic              valid_s1;
	item_t             item_s1;
	logic              valid_s2;
	result_t           result_s2;
	result_t           step_result;
	logic              advance;
	logic [ADDR_W-1:0] dev0_addr;
	logic [ADDR_W-1:0] dev1_addr;

	// pipeline moves when the result register is free or its transfer completes
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// input register: capture the transfer fields
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.op          <= op_t'(s_tuser);
			item_s1.device_sel  <= s_tdata[1:0];
			item_s1.reg_index   <= s_tdata[9:2];
			item_s1.write_data  <= s_tdata[25:10];
			item_s1.status_bits <= s_tdata[29:26];
			item_s1.error_bits  <= s_tdata[33:30];
			item_s1.rx_byte     <= s_tdata[41:34];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= step_result;
		end
	end

	i2c_ras_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.dev0_addr (dev0_addr),
		.dev1_addr (dev1_addr)
	);

	// sequencer state steps exactly when its result enters the result register
	i2c_ras_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance && valid_s1),
		.item      (item_s1),
		.dev0_addr (dev0_addr),
		.dev1_addr (dev1_addr),
		.result    (step_result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, result_s2.bus_error, result_s2.busy_res, result_s2.read_value,
		result_s2.read_done, result_s2.ack_ctrl, result_s2.stop_req, result_s2.start_req,
		result_s2.drive_byte, result_s2.drive_valid, result_s2.cmd_rejected};

endmodule

`default_nettype wire

@@ rtl/core/i2c_ras_checker.sv @@
// Port-level checks for the sequencer, bound to the top level.
`default_nettype none

module i2c_ras_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// a rejected command never requests start or drives a byte
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[10] && !m_tdata[1])
		else $error("rejected command produced bus activity");

	// a finished read leaves the sequencer idle and drives nothing
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> !m_tdata[31] && !m_tdata[1] && !m_tdata[11])
		else $error("read completion with busy or drive");

	// payload fields are zero when their flags are low
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1] || m_tdata[9:2] == 8'd0) &&
			(m_tdata[14] || m_tdata[30:15] == 16'd0))
		else $error("payload nonzero without its flag");

	// accepted command clears the error flag and marks busy
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[10] && !m_tdata[11] |-> m_tdata[31] && !m_tdata[32])
		else $error("start without busy or with stale error");

endmodule

bind i2c_register_access_sequencer i2c_ras_checker u_i2c_ras_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

@@ verif/i2c_register_access_sequencer_tb.sv @@
// Self-checking testbench for the I2C register access sequencer.
`default_nettype none

module i2c_register_access_sequencer_tb;

	import i2c_ras_pkg::*;

	// status_bits flag positions; only the lowest set flag is acted on
	localparam int STS_START    = 0;
	localparam int STS_ADDR_ACK = 1;
	localparam int STS_TX_EMPTY = 2;
	localparam int STS_RX_READY = 3;
	// error_bits flag position that makes the sequencer request stop
	localparam int ERR_ACK_FAIL = 0;

	localparam logic [1:0] DEV_SEL_ONE = 2'd1;

	localparam int RANDOM_ITEMS  = 1400;
	localparam int PHASES        = 4;
	localparam int PRESSURE_AT   = 300;  // results seen before the long receiver hold
	localparam int PRESSURE_LEN  = 150;

	// ------------------------------------------------------------------
	// Scoreboard: cycle-free model of the sequencer plus the queue of
	// results it still owes us.
	// ------------------------------------------------------------------
	class seq_scoreboard;
		logic [ADDR_W-1:0] dev_addr[2];
		seq_state_t        state;
		logic [ADDR_W-1:0] target;
		logic [7:0]        addr_byte, pointer_byte, tx_high, tx_low, rx_high;
		logic              read_pending, error_flag;
		result_t           owed_results[$];
		int unsigned       errors;

		function new();
			dev_addr[0]  = DEV0_ADDR_RST;
			dev_addr[1]  = DEV1_ADDR_RST;
			state        = ST_IDLE;
			target       = '0;
			addr_byte    = '0;
			pointer_byte = '0;
			tx_high      = '0;
			tx_low       = '0;
			rx_high      = '0;
			read_pending = 1'b0;
			error_flag   = 1'b0;
			errors       = 0;
		endfunction

		function void set_address(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
			dev_addr[idx] = val;
		endfunction

		// advance the model by one accepted transfer and queue its result
		function void note_item(item_t it);
			result_t r;
			r = '0;
			case (it.op)
				OP_WRITE, OP_READ: begin
					if (state != ST_IDLE || it.device_sel > DEV_SEL_ONE) begin
						r.cmd_rejected = 1'b1;
					end else begin
						target       = (it.device_sel == DEV_SEL_ZERO) ? dev_addr[0] : dev_addr[1];
						addr_byte    = {target, 1'b0};
						pointer_byte = it.reg_index;
						error_flag   = 1'b0;
						r.start_req  = 1'b1;
						if (it.op == OP_WRITE) begin
							tx_high      = it.write_data[15:8];
							tx_low       = it.write_data[7:0];
							read_pending = 1'b0;
							state        = ST_W_PTR;
						end else begin
							read_pending = 1'b1;
							state        = ST_R_PTR;
						end
					end
				end
				OP_STATUS: begin
					if (state != ST_IDLE) begin
						if (it.status_bits[STS_START]) begin
							r.drive_valid = 1'b1;
							r.drive_byte  = addr_byte;
						end else if (it.status_bits[STS_ADDR_ACK]) begin
							if (state == ST_R_ADDR) begin
								state      = ST_R_HIGH;
								r.ack_ctrl = ACK_ENABLE;
							end
						end else if (it.status_bits[STS_TX_EMPTY]) begin
							case (state)
								ST_W_PTR, ST_R_PTR: begin
									r.drive_valid = 1'b1;
									r.drive_byte  = pointer_byte;
									state = (state == ST_W_PTR) ? ST_W_HIGH : ST_W_END;
								end
								ST_W_HIGH: begin
									r.drive_valid = 1'b1;
									r.drive_byte  = tx_high;
									state         = ST_W_LOW;
								end
								ST_W_LOW: begin
									r.drive_valid = 1'b1;
									r.drive_byte  = tx_low;
									state         = ST_W_END;
								end
								ST_W_END: begin
									r.stop_req = 1'b1;
									if (read_pending) begin
										// repeated start with the read address
										read_pending = 1'b0;
										addr_byte    = {target, 1'b1};
										r.start_req  = 1'b1;
										state        = ST_R_ADDR;
									end else begin
										state = ST_IDLE;
									end
								end
								default: ;
							endcase
						end else if (it.status_bits[STS_RX_READY]) begin
							if (state == ST_R_HIGH) begin
								rx_high    = it.rx_byte;
								r.ack_ctrl = ACK_DISABLE;
								r.stop_req = 1'b1;
								state      = ST_R_LOW;
							end else if (state == ST_R_LOW) begin
								r.read_done  = 1'b1;
								r.read_value = {rx_high, it.rx_byte};
								state        = ST_IDLE;
							end
						end
					end
				end
				default: begin
					r.stop_req   = it.error_bits[ERR_ACK_FAIL];
					error_flag   = 1'b1;
					read_pending = 1'b0;
					state        = ST_IDLE;
				end
			endcase
			r.busy_res  = (state != ST_IDLE);
			r.bus_error = error_flag;
			owed_results.push_back(r);
		endfunction

		function void compare(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed_results.size() == 0) begin
				$error("result transfer with no expected result pending");
				errors++;
				return;
			end
			want = owed_results.pop_front();
			compare("cmd_rejected", want.cmd_rejected, got.cmd_rejected);
			compare("drive_valid", want.drive_valid, got.drive_valid);
			compare("drive_byte", want.drive_byte, got.drive_byte);
			compare("start_req", want.start_req, got.start_req);
			compare("stop_req", want.stop_req, got.stop_req);
			compare("ack_ctrl", want.ack_ctrl, got.ack_ctrl);
			compare("read_done", want.read_done, got.read_done);
			compare("read_value", want.read_value, got.read_value);
			compare("busy_res", want.busy_res, got.busy_res);
			compare("bus_error", want.bus_error, got.bus_error);
		endfunction
	endclass

	// ------------------------------------------------------------------
	// DUT hookup
	// ------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [47:0]          s_tdata = '0;  // device_sel, reg_index, write_data, status, errors, rx
	logic [1:0]           s_tuser = '0;  // op
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [39:0]          m_tdata;   // rejected, drive_valid/byte, start, stop, ack, done, value, busy, err

	i2c_register_access_sequencer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	seq_scoreboard sb = new();

	always #10 clk = ~clk;

	// hard stop in case a transfer never completes
	initial begin
		#5_000_000;
		$error("timeout: results still outstanding");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Result side: sample at rising edge, steer m_tready at falling edge.
	// ------------------------------------------------------------------
	int unsigned results_seen = 0;

	always @(posedge clk) begin
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.cmd_rejected = m_tdata[0];
			got.drive_valid  = m_tdata[1];
			got.drive_byte   = m_tdata[9:2];
			got.start_req    = m_tdata[10];
			got.stop_req     = m_tdata[11];
			got.ack_ctrl     = m_tdata[13:12];
			got.read_done    = m_tdata[14];
			got.read_value   = m_tdata[30:15];
			got.busy_res     = m_tdata[31];
			got.bus_error    = m_tdata[32];
			results_seen++;
			sb.check_result(got);
		end
	end

	// Receiver stall pattern: the mode is redrawn periodically from always
	// ready, coin flip, mostly ready and a fixed 4-of-7 duty. Once, after a
	// few hundred results, it holds off long enough to back up the input.
	int unsigned rx_cycle = 0;
	int unsigned rx_mode = 0;
	int unsigned hold_left = 0;
	bit          pressure_done = 1'b0;

	always @(negedge clk) begin
		rx_cycle++;
		if (!pressure_done && results_seen >= PRESSURE_AT) begin
			pressure_done = 1'b1;
			hold_left     = PRESSURE_LEN;
		end else if (hold_left == 0 && $urandom_range(0, 999) == 0) begin
			hold_left = $urandom_range(20, 60);
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 9) != 0);
				default: m_tready <= ((rx_cycle % 7) < 4);
			endcase
		end
		if (rx_cycle % 512 == 0)
			rx_mode = $urandom_range(0, 3);
	end

	// ------------------------------------------------------------------
	// Item side
	// ------------------------------------------------------------------
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          gapless = 1'b0;

	// one transfer: optional gap between bursts, then hold until accepted
	task automatic send(item_t it);
		int unsigned gap;
		if (!gapless && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			@(negedge clk) s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {6'd0, it.rx_byte, it.error_bits, it.status_bits,
			it.write_data, it.reg_index, it.device_sel};
		s_tuser  <= it.op;
		do @(posedge clk); while (!s_tready);
		sb.note_item(it);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
	endtask

	// every field random; callers override what matters
	function automatic item_t random_item(op_t op);
		item_t it;
		it.op          = op;
		it.device_sel  = 2'($urandom);
		it.reg_index   = 8'($urandom);
		it.write_data  = 16'($urandom);
		it.status_bits = 4'($urandom);
		it.error_bits  = 4'($urandom);
		it.rx_byte     = 8'($urandom);
		return it;
	endfunction

	// status word whose lowest set flag is flag_pos, higher flags random
	function automatic logic [3:0] status_for(int flag_pos);
		logic [3:0] s;
		s = 4'($urandom);
		s[flag_pos] = 1'b1;
		for (int k = 0; k < flag_pos; k++)
			s[k] = 1'b0;
		return s;
	endfunction

	task automatic send_cmd(op_t op, logic [1:0] dev, logic [7:0] ptr, logic [15:0] data);
		item_t it;
		it = random_item(op);
		it.device_sel = dev;
		it.reg_index  = ptr;
		it.write_data = data;
		send(it);
	endtask

	task automatic send_status(logic [3:0] bits, logic [7:0] rx);
		item_t it;
		it = random_item(OP_STATUS);
		it.status_bits = bits;
		it.rx_byte     = rx;
		send(it);
	endtask

	task automatic send_error(logic [3:0] bits);
		item_t it;
		it = random_item(OP_ERROR);
		it.error_bits = bits;
		send(it);
	endtask

	// anything at all: stray commands, stray events, aborts
	task automatic send_noise();
		send(random_item(op_t'($urandom_range(0, 3))));
	endtask

	// One well-formed register access with random content; sometimes noise
	// is mixed in or the access is cut short by an error event.
	task automatic random_access();
		int          flags[$];
		int          abort_at;
		logic [7:0]  rx;
		bit          is_read;
		// a stray event may have stranded the sequencer mid-transfer
		if (sb.state != ST_IDLE)
			send_error(4'($urandom));
		is_read = 1'($urandom_range(0, 1));
		send_cmd(is_read ? OP_READ : OP_WRITE, 2'($urandom_range(0, 1)),
			8'($urandom), 16'($urandom));
		if (is_read)
			flags = '{STS_START, STS_TX_EMPTY, STS_TX_EMPTY, STS_START,
				STS_ADDR_ACK, STS_RX_READY, STS_RX_READY};
		else
			flags = '{STS_START, STS_ADDR_ACK, STS_TX_EMPTY, STS_TX_EMPTY,
				STS_TX_EMPTY, STS_TX_EMPTY};
		abort_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, flags.size() - 1) : -1;
		foreach (flags[i]) begin
			if (i == abort_at) begin
				send_error(4'($urandom));
				return;
			end
			if ($urandom_range(0, 11) == 0)
				send_noise();
			rx = 8'($urandom);
			send_status(status_for(flags[i]), rx);
		end
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk) cfg_we <= 1'b0;
		sb.set_address(idx, val);
	endtask

	// stop offering, let every owed result come back plus pipeline slack
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.owed_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned phase_end;
		logic [ADDR_W-1:0] a0, a1;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Directed pass on reset addresses: idle events, invalid devices,
		// busy rejects, full write, full read with repeated start, aborts.
		send_status(4'hF, 8'hFF);                      // idle: ignored
		send_cmd(OP_WRITE, 2'd2, 8'h12, 16'h3456);     // invalid device
		send_cmd(OP_READ, 2'd3, 8'h12, 16'h3456);      // invalid device
		send_cmd(OP_WRITE, DEV_SEL_ZERO, 8'hFF, 16'hFFFF);
		send_cmd(OP_WRITE, DEV_SEL_ONE, 8'h00, 16'h0000); // busy: rejected
		send_status(4'h0, 8'h00);                      // no flags: ignored
		send_status(4'h1, 8'h00);                      // address byte out
		send_status(4'h2, 8'h00);                      // addr ack: not used in write
		send_status(4'h8, 8'hFF);                      // rx ready: wrong phase
		send_status(4'h4, 8'h00);                      // pointer
		send_status(4'h4, 8'h00);                      // high byte
		send_status(4'hC, 8'h00);                      // low byte
		send_status(4'h4, 8'h00);                      // stop, back to idle
		send_cmd(OP_READ, DEV_SEL_ONE, 8'h00, 16'hFFFF);
		send_status(4'h1, 8'h00);
		send_status(4'h4, 8'h00);                      // pointer
		send_status(4'h4, 8'h00);                      // stop + restart together
		send_status(4'h1, 8'h00);                      // read address
		send_status(4'hF, 8'h00);                      // lowest flag wins: start again
		send_status(4'hA, 8'h00);                      // ack enable
		send_status(4'h8, 8'hFF);                      // high byte, nack + stop
		send_status(4'h8, 8'h00);                      // low byte, word done
		send_cmd(OP_WRITE, DEV_SEL_ZERO, 8'h00, 16'h0000);
		send_error(4'h0);                              // flag set without stop
		send_cmd(OP_READ, DEV_SEL_ZERO, 8'hA5, 16'h0000); // clears the flag
		send_error(4'hF);                              // ack failure: stop
		send_error(4'h1);                              // error while idle
		drain();

		// Random phases, each on its own address setting; extremes first.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin a0 = 7'h00; a1 = 7'h7F; end
				1: begin a0 = 7'h7F; a1 = 7'h00; end
				2: begin a0 = 7'($urandom); a1 = 7'($urandom); end
				default: begin a0 = DEV0_ADDR_RST; a1 = DEV1_ADDR_RST; end
			endcase
			write_cfg(CFG_DEV0_ADDR, a0);
			write_cfg(CFG_DEV1_ADDR, a1);
			gapless   = (p == 1);
			phase_end = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(1, 4)) send_noise();
				else
					random_access();
			end
			drain();
		end

		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
